@@ rtl/pcm_pkg.sv @@
// Shared types and codes for the page cache MRU controller.
// No dependencies; every other file refers to it by scoped names.
package pcm_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned FILE_W   = 8;
  localparam int unsigned PAGE_W   = 32;
  localparam int unsigned BYTES_W  = 48;
  localparam int unsigned INIT_W   = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned FILL_W   = 2;
  localparam int unsigned CNT_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_FORGET = 2'd3
  } op_e;

  // Fill action reported with an access result.
  localparam logic [FILL_W-1:0] FILL_NONE = 2'd0;
  localparam logic [FILL_W-1:0] FILL_LOAD = 2'd1;
  localparam logic [FILL_W-1:0] FILL_ZERO = 2'd2;

  // Write miss fill mode carried by the request.
  localparam logic [INIT_W-1:0] INIT_NONE = 2'd0;
  localparam logic [INIT_W-1:0] INIT_ZERO = 2'd1;
  localparam logic [INIT_W-1:0] INIT_LOAD = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic do_access;
    logic flush_init;
    logic flush_step;
    logic do_forget;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic last;
  } status_t;

endpackage

@@ rtl/pcm_stream_if.sv @@
// Valid/ready channels for requests and results of the page cache controller.
// Depends on pcm_pkg for field widths.
interface pcm_in_if;
  logic                           valid;
  logic                           ready;
  logic [pcm_pkg::OP_W-1:0]       operation;
  logic [pcm_pkg::FILE_W-1:0]     file_id;
  logic [pcm_pkg::PAGE_W-1:0]     page_number;
  logic [pcm_pkg::BYTES_W-1:0]    file_bytes;
  logic [pcm_pkg::INIT_W-1:0]     write_init;

  modport source (
    output valid, operation, file_id, page_number, file_bytes, write_init,
    input  ready
  );
  modport sink (
    input  valid, operation, file_id, page_number, file_bytes, write_init,
    output ready
  );
endinterface

interface pcm_out_if;
  logic                           valid;
  logic                           ready;
  logic [pcm_pkg::SLOT_W-1:0]     slot;
  logic                           hit;
  logic [pcm_pkg::FILL_W-1:0]     fill_action;
  logic                           writeback_valid;
  logic [pcm_pkg::FILE_W-1:0]     writeback_file;
  logic [pcm_pkg::PAGE_W-1:0]     writeback_page;
  logic                           last;
  logic [pcm_pkg::CNT_W-1:0]      hit_total;
  logic [pcm_pkg::CNT_W-1:0]      miss_total;
  logic [pcm_pkg::CNT_W-1:0]      evict_total;
  logic [pcm_pkg::CNT_W-1:0]      flush_total;

  modport source (
    output valid, slot, hit, fill_action, writeback_valid, writeback_file,
           writeback_page, last, hit_total, miss_total, evict_total, flush_total,
    input  ready
  );
  modport sink (
    input  valid, slot, hit, fill_action, writeback_valid, writeback_file,
           writeback_page, last, hit_total, miss_total, evict_total, flush_total,
    output ready
  );
endinterface

@@ rtl/page_cache_mru_controller.sv @@
// Page cache MRU controller: tag and policy control for a fully associative
// write-back page cache of SLOTS slots with pages of 2**PAGE_SHIFT bytes. A
// read or write access latches the request, does a parallel tag compare with
// replacement into the result register, then holds the result until the
// result channel takes it; the next request is taken in the cycle after the
// result transfers, so no new request is taken while one is in progress.
// Flush-file latches the file's dirty pages, then gives one result per dirty
// page, each held until it transfers (one result without writeback if none
// is dirty); forget-file invalidates the file's slots and gives one result. The
// statistics totals on each result are the values after that result's update.
module page_cache_mru_controller #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcm_in_if.sink       in_i,
  pcm_out_if.source    out_o
);

  pcm_pkg::cmd_t    cmd;
  pcm_pkg::status_t sts;

  pcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcm_dpath #(
    .SLOTS      (SLOTS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (in_i.operation),
    .fid_i       (in_i.file_id),
    .page_i      (in_i.page_number),
    .bytes_i     (in_i.file_bytes),
    .init_i      (in_i.write_init),
    .slot_o      (out_o.slot),
    .hit_o       (out_o.hit),
    .fill_o      (out_o.fill_action),
    .wbv_o       (out_o.writeback_valid),
    .wbf_o       (out_o.writeback_file),
    .wbp_o       (out_o.writeback_page),
    .last_o      (out_o.last),
    .hit_cnt_o   (out_o.hit_total),
    .miss_cnt_o  (out_o.miss_total),
    .evict_cnt_o (out_o.evict_total),
    .flush_cnt_o (out_o.flush_total)
  );

endmodule

@@ rtl/pcm_ctrl.sv @@
// Sequencing state machine of the page cache controller.
// Depends on pcm_pkg for the command and status structs.
module pcm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pcm_pkg::status_t sts_i,
  output pcm_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.op) inside
          pcm_pkg::OP_READ, pcm_pkg::OP_WRITE: begin
            cmd_o.do_access = 1'b1;
            state_d         = S_OUT;
          end
          pcm_pkg::OP_FLUSH: begin
            cmd_o.flush_init = 1'b1;
            state_d          = S_FLUSH;
          end
          default: begin
            cmd_o.do_forget = 1'b1;
            state_d         = S_OUT;
          end
        endcase
      end
      S_FLUSH: begin
        cmd_o.flush_step = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        // Return for the next dirty page until the final result is taken.
        if (out_ready_i) begin
          state_d = sts_i.last ? S_IDLE : S_FLUSH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/pcm_dpath.sv @@
// Slot tag store, lookup, replacement, statistics and result register.
// Depends on pcm_pkg; driven by pcm_ctrl through cmd_t.
module pcm_dpath #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pcm_pkg::cmd_t                  cmd_i,
  output pcm_pkg::status_t               sts_o,
  input  logic [pcm_pkg::OP_W-1:0]       op_i,
  input  logic [pcm_pkg::FILE_W-1:0]     fid_i,
  input  logic [pcm_pkg::PAGE_W-1:0]     page_i,
  input  logic [pcm_pkg::BYTES_W-1:0]    bytes_i,
  input  logic [pcm_pkg::INIT_W-1:0]     init_i,
  output logic [pcm_pkg::SLOT_W-1:0]     slot_o,
  output logic                           hit_o,
  output logic [pcm_pkg::FILL_W-1:0]     fill_o,
  output logic                           wbv_o,
  output logic [pcm_pkg::FILE_W-1:0]     wbf_o,
  output logic [pcm_pkg::PAGE_W-1:0]     wbp_o,
  output logic                           last_o,
  output logic [pcm_pkg::CNT_W-1:0]      hit_cnt_o,
  output logic [pcm_pkg::CNT_W-1:0]      miss_cnt_o,
  output logic [pcm_pkg::CNT_W-1:0]      evict_cnt_o,
  output logic [pcm_pkg::CNT_W-1:0]      flush_cnt_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned XW = IW + pcm_pkg::SLOT_W;

  // Slot state
  logic [SLOTS-1:0]                valid_q, dirty_q;
  logic [pcm_pkg::FILE_W-1:0]      file_q [SLOTS];
  logic [pcm_pkg::PAGE_W-1:0]      page_q [SLOTS];
  logic [IW-1:0]                   recent_q;
  logic [pcm_pkg::CNT_W-1:0]       hit_cnt_q, miss_cnt_q, evict_cnt_q, flush_cnt_q;
  logic [SLOTS-1:0]                flush_vec_q;

  // Latched request
  pcm_pkg::op_e                    op_q;
  logic [pcm_pkg::FILE_W-1:0]      fid_q;
  logic [pcm_pkg::PAGE_W-1:0]      pg_q;
  logic [pcm_pkg::INIT_W-1:0]      init_q;
  logic                            past_end_q;

  // Result register
  logic [IW-1:0]                   oslot_q;
  logic                            ohit_q, owbv_q, olast_q;
  logic [pcm_pkg::FILL_W-1:0]      ofill_q;
  logic [pcm_pkg::FILE_W-1:0]      owbf_q;
  logic [pcm_pkg::PAGE_W-1:0]      owbp_q;

  function automatic logic [IW-1:0] lowest(input logic [SLOTS-1:0] v);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = IW'(i);
    end
    return idx;
  endfunction

  function automatic logic [pcm_pkg::CNT_W-1:0] sat_inc(input logic [pcm_pkg::CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  logic [SLOTS-1:0]           hit_vec, file_vec, flush_rem, flush_bit;
  logic                       any_hit, any_free, flush_any, evict, wb, is_write;
  logic [IW-1:0]              hit_idx, free_idx, flush_idx, acc_slot, rd_idx;
  logic [pcm_pkg::FILL_W-1:0] acc_fill;
  logic [pcm_pkg::PAGE_W-1:0] rd_page;
  logic [pcm_pkg::BYTES_W-1:0] first_byte;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      file_vec[i] = valid_q[i] && (file_q[i] == fid_q);
      hit_vec[i]  = file_vec[i] && (page_q[i] == pg_q);
    end
  end

  assign any_hit   = |hit_vec;
  assign any_free  = ~&valid_q;
  assign flush_any = |flush_vec_q;
  assign hit_idx   = lowest(hit_vec);
  assign free_idx  = lowest(~valid_q);
  assign flush_idx = lowest(flush_vec_q);
  assign flush_bit = SLOTS'(1) << flush_idx;
  assign flush_rem = flush_vec_q & ~flush_bit;
  assign is_write  = (op_q == pcm_pkg::OP_WRITE);
  assign evict     = !any_hit && !any_free;
  assign wb        = evict && dirty_q[recent_q];
  assign acc_slot  = any_hit ? hit_idx : (any_free ? free_idx : recent_q);
  assign rd_idx    = cmd_i.flush_step ? flush_idx : recent_q;
  assign rd_page   = page_q[rd_idx];
  assign first_byte = pcm_pkg::BYTES_W'(page_i) << PAGE_SHIFT;

  always_comb begin
    acc_fill = pcm_pkg::FILL_NONE;
    if (!any_hit) begin
      if (!is_write) begin
        acc_fill = past_end_q ? pcm_pkg::FILL_ZERO : pcm_pkg::FILL_LOAD;
      end else begin
        case (init_q)
          pcm_pkg::INIT_ZERO: acc_fill = pcm_pkg::FILL_ZERO;
          pcm_pkg::INIT_LOAD: acc_fill = past_end_q ? pcm_pkg::FILL_ZERO : pcm_pkg::FILL_LOAD;
          default:            acc_fill = pcm_pkg::FILL_NONE;
        endcase
      end
    end
  end

  // Control state: valid and dirty marks, MRU slot, counters, flush walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_q     <= '0;
      recent_q    <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      flush_cnt_q <= '0;
      flush_vec_q <= '0;
    end else begin
      if (cmd_i.do_access) begin
        recent_q <= acc_slot;
        if (any_hit) begin
          hit_cnt_q <= sat_inc(hit_cnt_q);
          if (is_write) dirty_q[acc_slot] <= 1'b1;
        end else begin
          miss_cnt_q        <= sat_inc(miss_cnt_q);
          valid_q[acc_slot] <= 1'b1;
          dirty_q[acc_slot] <= is_write;
          if (evict) evict_cnt_q <= sat_inc(evict_cnt_q);
          if (wb)    flush_cnt_q <= sat_inc(flush_cnt_q);
        end
      end
      if (cmd_i.flush_init) begin
        flush_vec_q <= file_vec & dirty_q;
      end
      if (cmd_i.flush_step && flush_any) begin
        dirty_q[flush_idx] <= 1'b0;
        flush_vec_q        <= flush_rem;
        flush_cnt_q        <= sat_inc(flush_cnt_q);
      end
      if (cmd_i.do_forget) begin
        valid_q <= valid_q & ~file_vec;
        dirty_q <= dirty_q & ~file_vec;
      end
    end
  end

  // Tags, latched request and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q       <= pcm_pkg::op_e'(op_i);
      fid_q      <= fid_i;
      pg_q       <= page_i;
      init_q     <= init_i;
      past_end_q <= (first_byte >= bytes_i);
    end
    if (cmd_i.do_access) begin
      if (!any_hit) begin
        file_q[acc_slot] <= fid_q;
        page_q[acc_slot] <= pg_q;
      end
      oslot_q <= acc_slot;
      ohit_q  <= any_hit;
      ofill_q <= acc_fill;
      owbv_q  <= wb;
      owbf_q  <= wb ? file_q[recent_q] : '0;
      owbp_q  <= wb ? rd_page : '0;
      olast_q <= 1'b1;
    end
    if (cmd_i.flush_step) begin
      ohit_q  <= 1'b0;
      ofill_q <= pcm_pkg::FILL_NONE;
      if (flush_any) begin
        oslot_q <= flush_idx;
        owbv_q  <= 1'b1;
        owbf_q  <= fid_q;
        owbp_q  <= rd_page;
        olast_q <= (flush_rem == '0);
      end else begin
        oslot_q <= '0;
        owbv_q  <= 1'b0;
        owbf_q  <= '0;
        owbp_q  <= '0;
        olast_q <= 1'b1;
      end
    end
    if (cmd_i.do_forget) begin
      oslot_q <= '0;
      ohit_q  <= 1'b0;
      ofill_q <= pcm_pkg::FILL_NONE;
      owbv_q  <= 1'b0;
      owbf_q  <= '0;
      owbp_q  <= '0;
      olast_q <= 1'b1;
    end
  end

  logic [XW-1:0] oslot_ext;
  assign oslot_ext = XW'(oslot_q);

  assign sts_o.op     = op_q;
  assign sts_o.last   = olast_q;
  assign slot_o       = oslot_ext[pcm_pkg::SLOT_W-1:0];
  assign hit_o        = ohit_q;
  assign fill_o       = ofill_q;
  assign wbv_o        = owbv_q;
  assign wbf_o        = owbf_q;
  assign wbp_o        = owbp_q;
  assign last_o       = olast_q;
  assign hit_cnt_o    = hit_cnt_q;
  assign miss_cnt_o   = miss_cnt_q;
  assign evict_cnt_o  = evict_cnt_q;
  assign flush_cnt_o  = flush_cnt_q;

  a_access_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_access |=> valid_q[oslot_q])
    else $error("accessed slot not valid after access");

  a_flush_clears_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.flush_step && flush_any) |=> !dirty_q[$past(flush_idx)])
    else $error("flushed slot still dirty");

  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_access |=> !(ohit_q && (owbv_q || ofill_q != pcm_pkg::FILL_NONE)))
    else $error("hit result carries fill or writeback");

  a_counters_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_cnt_q >= $past(hit_cnt_q)) && (flush_cnt_q >= $past(flush_cnt_q)))
    else $error("statistics counter went backward");

endmodule
